// ===== rtl/core/y411rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// y411rgb_pkg
// Shared types and constants of the packed 4:1:1 to RGB24 converter.
// ----------------------------------------------------------------------------
package y411rgb_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Coefficients in millionths; scaled and rounded at elaboration.
    localparam longint MICRO      = 1000000;
    localparam longint RV_MICRO   = 1370705;
    localparam longint GV_MICRO   = 698001;
    localparam longint GU_MICRO   = 337633;
    localparam longint BU_MICRO   = 1732446;

    localparam logic [8:0] CHROMA_OFFSET = 9'd128;
    localparam logic [7:0] PIX_MAX       = 8'd255;

    typedef enum logic [5:0] {
        PH_U  = 6'b000001,
        PH_Y1 = 6'b000010,
        PH_Y2 = 6'b000100,
        PH_V  = 6'b001000,
        PH_Y3 = 6'b010000,
        PH_Y4 = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_in_run;
    } t_out_item;

    // One queue entry: a byte that causes pixels. A pair job carries two
    // luma values that share the chroma; a single job uses y0 only.
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] v;
        logic       pair;
    } t_job;

endpackage

// ===== rtl/core/y411rgb_front.sv =====
// ----------------------------------------------------------------------------
// y411rgb_front
// Tracks the byte phase, holds chroma and early luma, and posts pixel jobs.
// ----------------------------------------------------------------------------
module y411rgb_front
    import y411rgb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    input  logic     i_q_ready,
    output logic     o_push,
    output t_job     o_job
);

    t_phase     r_phase, n_phase, w_eff;
    logic [7:0] r_u, n_u;
    logic [7:0] r_v, n_v;
    logic [7:0] r_y0, n_y0;
    logic [7:0] r_y1, n_y1;
    logic       w_accept;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    assign w_eff    = i_data.frame_start ? PH_U : r_phase;

    always_comb begin
        n_phase = r_phase;
        n_u     = r_u;
        n_v     = r_v;
        n_y0    = r_y0;
        n_y1    = r_y1;
        o_push  = 1'b0;
        o_job   = '{y0: i_data.data_byte, y1: r_y1, u: r_u, v: r_v, pair: 1'b0};
        if (w_accept) begin
            case (w_eff)
                PH_Y1: begin
                    n_y0    = i_data.data_byte;
                    n_phase = PH_Y2;
                end
                PH_Y2: begin
                    n_y1    = i_data.data_byte;
                    n_phase = PH_V;
                end
                PH_V: begin
                    n_v     = i_data.data_byte;
                    o_push  = 1'b1;
                    o_job   = '{y0: r_y0, y1: r_y1, u: r_u, v: i_data.data_byte,
                                pair: 1'b1};
                    n_phase = PH_Y3;
                end
                PH_Y3: begin
                    o_push  = 1'b1;
                    n_phase = PH_Y4;
                end
                PH_Y4: begin
                    o_push  = 1'b1;
                    n_phase = PH_U;
                end
                default: begin
                    // The U byte, and any phase code that should not occur.
                    n_u     = i_data.data_byte;
                    n_phase = PH_Y1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_U;
            r_u     <= '0;
            r_v     <= '0;
        end else begin
            r_phase <= n_phase;
            r_u     <= n_u;
            r_v     <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y0 <= n_y0;
        r_y1 <= n_y1;
    end

endmodule

// ===== rtl/core/y411rgb_queue.sv =====
// ----------------------------------------------------------------------------
// y411rgb_queue
// Short job queue between the byte front end and the pixel pipeline.
// ----------------------------------------------------------------------------
module y411rgb_queue
    import y411rgb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_not_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_not_full = (r_cnt != FULL_CNT);
    assign o_valid    = (r_cnt != '0);
    assign o_job      = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/y411rgb_back.sv =====
// ----------------------------------------------------------------------------
// y411rgb_back
// Pixel pipeline: one luma per cycle unless stalled; multiplies, sums, clamps.
// ----------------------------------------------------------------------------
module y411rgb_back
    import y411rgb_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int KW = COEF_FRAC_BITS + 2;
    localparam int PW = KW + 10;
    localparam int SW = COEF_FRAC_BITS + 13;
    localparam logic [KW-1:0] K_RV =
        KW'(((64'(RV_MICRO) << COEF_FRAC_BITS) + 64'(MICRO / 2)) / 64'(MICRO));
    localparam logic [KW-1:0] K_GV =
        KW'(((64'(GV_MICRO) << COEF_FRAC_BITS) + 64'(MICRO / 2)) / 64'(MICRO));
    localparam logic [KW-1:0] K_GU =
        KW'(((64'(GU_MICRO) << COEF_FRAC_BITS) + 64'(MICRO / 2)) / 64'(MICRO));
    localparam logic [KW-1:0] K_BU =
        KW'(((64'(BU_MICRO) << COEF_FRAC_BITS) + 64'(MICRO / 2)) / 64'(MICRO));

    function automatic logic [7:0] floor_clamp(input logic signed [SW-1:0] sum);
        logic signed [SW-1:0] whole;
        whole = sum >>> COEF_FRAC_BITS;
        if (whole < 0) begin
            return 8'd0;
        end else if (whole > SW'(PIX_MAX)) begin
            return PIX_MAX;
        end
        return whole[7:0];
    endfunction

    // Select stage
    logic       r_a_valid;
    logic [7:0] r_a_y, r_a_u, r_a_v;
    logic       r_a_last;
    logic       r_second, n_second;
    logic       w_a_ready, w_take;

    // Product stage
    logic                 r_b_valid;
    logic [7:0]           r_b_y;
    logic                 r_b_last;
    logic signed [PW-1:0] r_b_rv, r_b_gv, r_b_gu, r_b_bu;
    logic                 w_b_ready;
    logic signed [8:0]    w_cu, w_cv;

    // Output stage
    logic                 r_out_valid;
    t_out_item            r_out;
    logic                 w_c_ready;
    logic signed [SW-1:0] w_ys, w_sr, w_sg, w_sb;

    assign w_c_ready = !r_out_valid || i_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign w_take    = i_job_valid && w_a_ready;
    // A pair job stays at the queue head until its second pixel is taken.
    assign o_pop     = w_take && (!i_job.pair || r_second);

    always_comb begin
        n_second = r_second;
        if (w_take) begin
            n_second = i_job.pair && !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_second  <= 1'b0;
        end else begin
            r_second <= n_second;
            if (w_a_ready) begin
                r_a_valid <= i_job_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_y    <= r_second ? i_job.y1 : i_job.y0;
            r_a_u    <= i_job.u;
            r_a_v    <= i_job.v;
            r_a_last <= !i_job.pair || r_second;
        end
    end

    assign w_cu = $signed({1'b0, r_a_u}) - $signed(CHROMA_OFFSET);
    assign w_cv = $signed({1'b0, r_a_v}) - $signed(CHROMA_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_valid) begin
            r_b_y    <= r_a_y;
            r_b_last <= r_a_last;
            r_b_rv   <= PW'(w_cv) * PW'($signed({1'b0, K_RV}));
            r_b_gv   <= PW'(w_cv) * PW'($signed({1'b0, K_GV}));
            r_b_gu   <= PW'(w_cu) * PW'($signed({1'b0, K_GU}));
            r_b_bu   <= PW'(w_cu) * PW'($signed({1'b0, K_BU}));
        end
    end

    assign w_ys = $signed(SW'({r_b_y, {COEF_FRAC_BITS{1'b0}}}));
    assign w_sr = w_ys + SW'(r_b_rv);
    assign w_sg = w_ys - SW'(r_b_gv) - SW'(r_b_gu);
    assign w_sb = w_ys + SW'(r_b_bu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_c_ready) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && r_b_valid) begin
            r_out.red         <= floor_clamp(w_sr);
            r_out.green       <= floor_clamp(w_sg);
            r_out.blue        <= floor_clamp(w_sb);
            r_out.last_in_run <= r_b_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/yuv411_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// yuv411_to_rgb_converter_core
// Packed 4:1:1 (U,Y1,Y2,V,Y3,Y4) camera bytes in, RGB24 pixels out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while o_ready is high and gives four
// pixels for every six bytes: two on the V byte (Y1's pixel, then Y2's, the
// second marked as last of its beat) and one each on Y3 and Y4. A byte with
// frame_start set is taken as U and restarts the phase. A pixel goes through
// the queue and the select, product and output registers. The front end
// posts one job per pixel-producing byte into a short queue; the pixel
// pipeline issues one pixel per cycle while the output is not stalled, and a
// V job stays at the queue head until both its pixels are taken. When the
// output stalls, the queue fills and input ready drops at QUEUE_DEPTH jobs.
// ----------------------------------------------------------------------------
module yuv411_to_rgb_converter_core
    import y411rgb_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic w_q_not_full;
    logic w_push;
    t_job w_push_job;
    logic w_job_valid;
    t_job w_head_job;
    logic w_pop;

    y411rgb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_q_ready (w_q_not_full),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    y411rgb_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_push_job),
        .o_not_full (w_q_not_full),
        .o_valid    (w_job_valid),
        .i_pop      (w_pop),
        .o_job      (w_head_job)
    );

    y411rgb_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
